// File: rtl/tga_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the targa pixel-stream decoder.
// Depends on nothing; every other file of the block depends on it.
package tga_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned DIM_W   = 16;
    localparam int unsigned INDEX_W = 32;
    localparam int unsigned DEPTH_W = 6;

    // Pixel depths that the decoder supports, in bits per pixel.
    localparam logic [DEPTH_W-1:0] PIXEL_BITS_16 = 6'd16;
    localparam logic [DEPTH_W-1:0] PIXEL_BITS_24 = 6'd24;
    localparam logic [DEPTH_W-1:0] PIXEL_BITS_32 = 6'd32;
    localparam logic [DEPTH_W-1:0] PIXEL_BITS_RESET = PIXEL_BITS_24;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_RLE_MODE     = 2'd0,
        CFG_PIXEL_BITS   = 2'd1,
        CFG_IMAGE_WIDTH  = 2'd2,
        CFG_IMAGE_HEIGHT = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        DEPTH_16,
        DEPTH_24,
        DEPTH_32,
        DEPTH_BAD
    } t_depth;

    typedef struct packed {
        t_depth     depth;
        logic       bad;
        logic [2:0] bytes;
    } t_depth_info;

    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] alpha;
    } t_rgba;

endpackage

// File: rtl/tga_byte_if.sv
`timescale 1ns / 1ps
// Byte channel into the targa decoder: valid, ready and one data byte.
// Depends on tga_pkg for the byte width.
interface tga_byte_if;
    logic                      valid;
    logic                      ready;
    logic [tga_pkg::BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

// File: rtl/tga_result_if.sv
`timescale 1ns / 1ps
// Result channel out of the targa decoder: valid, ready and one pixel or run.
// Depends on tga_pkg for the field widths.
interface tga_result_if;
    logic                        valid;
    logic                        ready;
    logic [tga_pkg::INDEX_W-1:0] pixel_index;
    logic [tga_pkg::BYTE_W-1:0]  run_count;
    logic [tga_pkg::BYTE_W-1:0]  red;
    logic [tga_pkg::BYTE_W-1:0]  green;
    logic [tga_pkg::BYTE_W-1:0]  blue;
    logic [tga_pkg::BYTE_W-1:0]  alpha;
    logic                        image_done;
    logic                        status;

    modport source (output valid, output pixel_index, output run_count, output red,
                    output green, output blue, output alpha, output image_done,
                    output status, input ready);
    modport sink   (input valid, input pixel_index, input run_count, input red,
                    input green, input blue, input alpha, input image_done,
                    input status, output ready);
endinterface

// File: rtl/tga_pixel_fmt.sv
`timescale 1ns / 1ps
// Depth decode and colour reordering for one gathered targa pixel word.
// Depends on tga_pkg.
module tga_pixel_fmt (
    input  logic [tga_pkg::DEPTH_W-1:0] i_pixel_bits,
    input  logic [31:0]                 i_word,
    output tga_pkg::t_depth_info        o_info,
    output tga_pkg::t_rgba              o_rgba
);
    import tga_pkg::*;

    always_comb begin
        case (i_pixel_bits)
            PIXEL_BITS_16: o_info = '{depth: DEPTH_16, bad: 1'b0, bytes: 3'd2};
            PIXEL_BITS_24: o_info = '{depth: DEPTH_24, bad: 1'b0, bytes: 3'd3};
            PIXEL_BITS_32: o_info = '{depth: DEPTH_32, bad: 1'b0, bytes: 3'd4};
            default:       o_info = '{depth: DEPTH_BAD, bad: 1'b1, bytes: 3'd0};
        endcase
    end

    // Files store B,G,R(,A); 16-bit pixels are x-5-5-5, low byte first.
    always_comb begin
        case (o_info.depth)
            DEPTH_16: begin
                o_rgba.blue  = {i_word[4:0], 3'b000};
                o_rgba.green = {i_word[9:5], 3'b000};
                o_rgba.red   = {i_word[14:10], 3'b000};
                o_rgba.alpha = '0;
            end
            DEPTH_24: begin
                o_rgba.blue  = i_word[7:0];
                o_rgba.green = i_word[15:8];
                o_rgba.red   = i_word[23:16];
                o_rgba.alpha = '0;
            end
            DEPTH_32: begin
                o_rgba.blue  = i_word[7:0];
                o_rgba.green = i_word[15:8];
                o_rgba.red   = i_word[23:16];
                o_rgba.alpha = i_word[31:24];
            end
            default: begin
                o_rgba = '0;
            end
        endcase
    end

endmodule

// File: rtl/tga_pixel_stream_decoder_core.sv
`timescale 1ns / 1ps
// Top level of the targa pixel-stream decoder: input register, decode, result register.
// Depends on tga_pkg, tga_byte_if, tga_result_if and tga_pixel_fmt.

// The decoder takes the pixel-data section of a targa image one byte per
// transaction and sustains one byte per clock cycle while no result waits on
// o_pix_out.ready. Each accepted byte is held in an input register, is decoded
// against the current image state, and any result lands in an output register
// that holds it valid until it is taken; while it waits, a byte in the input
// register waits too. The byte rate is set by the single decode
// stage between those two registers, which holds the remaining-pixel count
// and the run clamp; the width times height product is kept in a register of
// its own that is refreshed whenever either dimension is written, so the
// multiply stays out of the decode path. Uncompressed 24 and 32-bit pixels are
// reordered to R,G,B(,A); 16-bit 5-5-5 pixels are widened by three bits per
// field. In run-length mode a header byte gives no result, a raw packet gives
// one result per pixel, and a repeat packet gives a single result whose
// run_count tells how many pixels take its colour, clamped to the pixels left
// in the image. Once the last pixel has been produced, bytes are taken and
// dropped until reset. With a pixel depth other than 16, 24 or 32 every byte
// taken before the image is complete gives a result with status set and all
// other fields zero. Configuration is written through i_cfg_we, i_cfg_index
// and i_cfg_data and must only change while no transaction is in flight.
module tga_pixel_stream_decoder_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_index,
    input  logic [tga_pkg::CFG_W-1:0]  i_cfg_data,
    tga_byte_if.sink                   i_pix_in,
    tga_result_if.source               o_pix_out
);
    import tga_pkg::*;

    // Configuration registers.
    logic               r_rle_mode;
    logic [DEPTH_W-1:0] r_pixel_bits;
    logic [DIM_W-1:0]   r_image_width;
    logic [DIM_W-1:0]   r_image_height;

    // Pixel count of the whole image, kept equal to width times height.
    logic [INDEX_W-1:0] r_total;
    logic [INDEX_W-1:0] n_total;

    // Decoder state.
    logic [1:0]         r_byte_phase;
    logic               r_packet_is_repeat;
    logic [7:0]         r_packet_remaining;
    logic [31:0]        r_colour_gather;
    logic [INDEX_W-1:0] r_pixels_done;
    logic               r_finished;

    logic [1:0]         n_byte_phase;
    logic               n_packet_is_repeat;
    logic [7:0]         n_packet_remaining;
    logic [31:0]        n_colour_gather;
    logic [INDEX_W-1:0] n_pixels_done;
    logic               n_finished;

    // Input register.
    logic               r_s1_valid;
    logic [BYTE_W-1:0]  r_s1_byte;

    // Result register.
    logic               r_out_valid;
    logic [INDEX_W-1:0] r_out_index;
    logic [BYTE_W-1:0]  r_out_run;
    t_rgba              r_out_rgba;
    logic               r_out_done;
    logic               r_out_status;

    logic               n_out_load;
    logic [INDEX_W-1:0] n_out_index;
    logic [BYTE_W-1:0]  n_out_run;
    t_rgba              n_out_rgba;
    logic               n_out_done;
    logic               n_out_status;

    logic               out_free;
    logic               s1_fire;
    logic [INDEX_W-1:0] total;
    logic [INDEX_W-1:0] left;
    logic               complete;
    logic               is_header;
    logic               pixel_end;
    logic [31:0]        word;
    logic [BYTE_W-1:0]  run;
    logic [INDEX_W-1:0] pixels_after;
    t_depth_info        info;
    t_rgba              rgba;

    // Handshake: the input register moves on whenever the result register
    // can take its outcome, so one transaction per cycle flows through.
    assign out_free       = !r_out_valid || o_pix_out.ready;
    assign s1_fire        = r_s1_valid && out_free;
    assign i_pix_in.ready = !r_s1_valid || out_free;

    // The byte at the current phase is merged into the gathered word here,
    // so the completing byte of a pixel never needs a register of its own.
    assign word = r_colour_gather | ({24'd0, r_s1_byte} << {r_byte_phase, 3'b000});

    tga_pixel_fmt u_fmt (
        .i_pixel_bits (r_pixel_bits),
        .i_word       (word),
        .o_info       (info),
        .o_rgba       (rgba)
    );

    // The product is formed from the written dimension and the stored one,
    // so it is ready in the same cycle as the dimension register itself.
    always_comb begin
        n_total = r_total;
        if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_IMAGE_WIDTH:  n_total = {16'd0, i_cfg_data[DIM_W-1:0]} *
                                            {16'd0, r_image_height};
                CFG_IMAGE_HEIGHT: n_total = {16'd0, r_image_width} *
                                            {16'd0, i_cfg_data[DIM_W-1:0]};
                default:          n_total = r_total;
            endcase
        end
    end

    assign total        = r_total;
    assign left         = total - r_pixels_done;
    assign complete     = r_finished || (r_pixels_done >= total);
    assign is_header    = r_rle_mode && (r_packet_remaining == 8'd0);
    assign pixel_end    = ({1'b0, r_byte_phase} + 3'd1) >= info.bytes;

    // A repeat run covers the whole packet unless the image ends sooner.
    always_comb begin
        if (r_rle_mode && r_packet_is_repeat) begin
            if (left >= {24'd0, r_packet_remaining}) begin
                run = r_packet_remaining;
            end else begin
                run = left[7:0];
            end
        end else begin
            run = 8'd1;
        end
    end

    assign pixels_after = r_pixels_done + {24'd0, run};

    always_comb begin
        n_byte_phase       = r_byte_phase;
        n_packet_is_repeat = r_packet_is_repeat;
        n_packet_remaining = r_packet_remaining;
        n_colour_gather    = r_colour_gather;
        n_pixels_done      = r_pixels_done;
        n_finished         = r_finished;
        n_out_load         = 1'b0;
        n_out_index        = r_pixels_done;
        n_out_run          = run;
        n_out_rgba         = rgba;
        n_out_done         = 1'b0;
        n_out_status       = 1'b0;

        if (s1_fire && !complete) begin
            if (info.bad) begin
                // Unsupported depth: report it and leave the state alone.
                n_out_load   = 1'b1;
                n_out_index  = '0;
                n_out_run    = '0;
                n_out_rgba   = '0;
                n_out_status = 1'b1;
            end else if (is_header) begin
                // Raw packets hold header+1 pixels, repeat packets header-127;
                // both come out as the low seven bits plus one.
                n_packet_is_repeat = r_s1_byte[7];
                n_packet_remaining = {1'b0, r_s1_byte[6:0]} + 8'd1;
                n_byte_phase       = '0;
                n_colour_gather    = '0;
            end else if (!pixel_end) begin
                n_byte_phase    = r_byte_phase + 2'd1;
                n_colour_gather = word;
            end else begin
                n_byte_phase    = '0;
                n_colour_gather = '0;
                if (r_rle_mode) begin
                    if (r_packet_is_repeat) begin
                        n_packet_remaining = '0;
                    end else begin
                        n_packet_remaining = r_packet_remaining - 8'd1;
                    end
                end
                n_pixels_done = pixels_after;
                n_finished    = pixels_after >= total;
                n_out_load    = 1'b1;
                n_out_done    = pixels_after >= total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rle_mode     <= 1'b0;
            r_pixel_bits   <= PIXEL_BITS_RESET;
            r_image_width  <= '0;
            r_image_height <= '0;
            r_total        <= '0;
        end else begin
            r_total <= n_total;
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_RLE_MODE:     r_rle_mode     <= i_cfg_data[0];
                    CFG_PIXEL_BITS:   r_pixel_bits   <= i_cfg_data[DEPTH_W-1:0];
                    CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[DIM_W-1:0];
                    CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[DIM_W-1:0];
                    default:          r_rle_mode     <= r_rle_mode;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_phase       <= '0;
            r_packet_is_repeat <= 1'b0;
            r_packet_remaining <= '0;
            r_colour_gather    <= '0;
            r_pixels_done      <= '0;
            r_finished         <= 1'b0;
            r_s1_valid         <= 1'b0;
            r_out_valid        <= 1'b0;
        end else begin
            r_byte_phase       <= n_byte_phase;
            r_packet_is_repeat <= n_packet_is_repeat;
            r_packet_remaining <= n_packet_remaining;
            r_colour_gather    <= n_colour_gather;
            r_pixels_done      <= n_pixels_done;
            r_finished         <= n_finished;
            if (i_pix_in.ready) begin
                r_s1_valid <= i_pix_in.valid;
            end
            if (n_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_pix_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pix_in.valid && i_pix_in.ready) begin
            r_s1_byte <= i_pix_in.data_byte;
        end
        if (n_out_load) begin
            r_out_index  <= n_out_index;
            r_out_run    <= n_out_run;
            r_out_rgba   <= n_out_rgba;
            r_out_done   <= n_out_done;
            r_out_status <= n_out_status;
        end
    end

    assign o_pix_out.valid       = r_out_valid;
    assign o_pix_out.pixel_index = r_out_index;
    assign o_pix_out.run_count   = r_out_run;
    assign o_pix_out.red         = r_out_rgba.red;
    assign o_pix_out.green       = r_out_rgba.green;
    assign o_pix_out.blue        = r_out_rgba.blue;
    assign o_pix_out.alpha       = r_out_rgba.alpha;
    assign o_pix_out.image_done  = r_out_done;
    assign o_pix_out.status      = r_out_status;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for tga_pixel_stream_decoder_core: a directed walk, then random bytes.
// Depends on tga_pkg, tga_byte_if, tga_result_if and the decoder RTL.
module tb_top;
    import tga_pkg::*;

    localparam int MAX_WAIT      = 8;    // longest idle stretch on either channel
    localparam int SETTLE_CYCLES = 6;    // covers the two-register latency of the core
    localparam int RANDOM_BYTES  = 1600;

    // One expected transaction on the result channel.
    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [BYTE_W-1:0]  run;
        t_rgba              colour;
        logic               done;
        logic               status;
    } t_pixel_result;

    typedef enum logic [1:0] {ROW_REG, ROW_BYTE} t_row_kind;

    // How a directed byte is checked: against the decoder model, as giving nothing,
    // or against a result written out in the row itself.
    typedef enum logic [1:0] {FROM_DECODER, NO_PIXEL, GIVEN_PIXEL} t_pixel_check;

    typedef struct {
        t_row_kind     kind;
        t_cfg_index    reg_index;
        logic [15:0]   value;
        t_pixel_check  check;
        t_pixel_result given;
    } t_stim_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              cfg_we;
    t_cfg_index        cfg_index;
    logic [CFG_W-1:0]  cfg_data;

    tga_byte_if   byte_ch ();
    tga_result_if pix_ch ();

    tga_pixel_stream_decoder_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_pix_in    (byte_ch),
        .o_pix_out   (pix_ch)
    );

    // Decoder model state. The register copies start at their reset values.
    logic                cfg_rle    = 1'b0;
    logic [DEPTH_W-1:0]  cfg_bits   = PIXEL_BITS_RESET;
    logic [DIM_W-1:0]    cfg_width  = '0;
    logic [DIM_W-1:0]    cfg_height = '0;
    logic [1:0]          gather_phase   = '0;
    logic                in_repeat      = 1'b0;
    logic [7:0]          packet_left    = '0;
    logic [31:0]         gathered       = '0;
    logic [31:0]         pixels_out     = '0;
    logic                image_finished = 1'b0;

    t_pixel_result expected_pixels[$];
    t_stim_row     stim_rows[$];

    int  failures      = 0;
    int  bytes_sent    = 0;
    int  results_seen  = 0;
    int  settings_used = 0;
    bit  no_idle       = 1'b0;

    always begin
        #5 i_clk = ~i_clk;
    end

    // Every input is known from time zero; reset is asserted once, at the start.
    initial begin
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_RLE_MODE;
        cfg_data          = '0;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = '0;
        pix_ch.ready      = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Decoder model: consumes one accepted byte and returns 1 when it yields a result.
    // The image is complete once finished, or once pixels_out reaches width times
    // height; from then on bytes are swallowed. An unsupported depth gives a bare
    // error status and leaves the state alone.
    function automatic bit decode_byte(input logic [7:0] value, output t_pixel_result res);
        logic [31:0] total;
        logic [31:0] left;
        logic [31:0] run;
        t_depth      depth;
        int          bytes;
        total = 32'(cfg_width) * 32'(cfg_height);
        res   = '0;
        if (image_finished || pixels_out >= total) return 1'b0;
        case (cfg_bits)
            PIXEL_BITS_16: begin depth = DEPTH_16; bytes = 2; end
            PIXEL_BITS_24: begin depth = DEPTH_24; bytes = 3; end
            PIXEL_BITS_32: begin depth = DEPTH_32; bytes = 4; end
            default: begin depth = DEPTH_BAD; bytes = 0; end
        endcase
        if (depth == DEPTH_BAD) begin
            res.status = 1'b1;
            return 1'b1;
        end
        // With packet_left at zero the byte is a run-length packet header.
        if (cfg_rle && packet_left == 0) begin
            if (value < 8'd128) begin
                in_repeat   = 1'b0;
                packet_left = value + 8'd1;
            end else begin
                in_repeat   = 1'b1;
                packet_left = value - 8'd127;
            end
            gather_phase = '0;
            gathered     = '0;
            return 1'b0;
        end
        gathered = gathered | (32'(value) << (8 * gather_phase));
        if (gather_phase + 1 < bytes) begin
            gather_phase = gather_phase + 2'd1;
            return 1'b0;
        end
        if (depth == DEPTH_16) begin
            // x-5-5-5, low byte first; each field is widened by three zero bits.
            res.colour.blue  = {gathered[4:0], 3'b000};
            res.colour.green = {gathered[9:5], 3'b000};
            res.colour.red   = {gathered[14:10], 3'b000};
        end else begin
            res.colour.blue  = gathered[7:0];
            res.colour.green = gathered[15:8];
            res.colour.red   = gathered[23:16];
            res.colour.alpha = (depth == DEPTH_32) ? gathered[31:24] : 8'h00;
        end
        gather_phase = '0;
        gathered     = '0;
        left = total - pixels_out;
        run  = 32'd1;
        if (cfg_rle) begin
            if (in_repeat) begin
                // A repeat run never reaches past the last pixel of the image.
                run         = 32'(packet_left);
                if (run > left) run = left;
                packet_left = '0;
            end else begin
                packet_left = packet_left - 8'd1;
            end
        end
        res.index  = pixels_out;
        res.run    = run[7:0];
        pixels_out = pixels_out + run;
        if (pixels_out >= total) image_finished = 1'b1;
        res.done   = image_finished;
        return 1'b1;
    endfunction

    function automatic void add_reg(input t_cfg_index idx, input logic [15:0] value);
        t_stim_row row;
        row.kind      = ROW_REG;
        row.reg_index = idx;
        row.value     = value;
        row.check     = NO_PIXEL;
        row.given     = '0;
        stim_rows     = {stim_rows, row};
    endfunction

    function automatic void add_byte(input logic [7:0] value, input t_pixel_check check);
        t_stim_row row;
        row.kind      = ROW_BYTE;
        row.reg_index = CFG_RLE_MODE;
        row.value     = 16'(value);
        row.check     = check;
        row.given     = '0;
        stim_rows     = {stim_rows, row};
    endfunction

    // A byte whose result is plain to see: single pixel, not the last of the image.
    function automatic void add_given(input logic [7:0] value, input logic [31:0] index,
                                      input logic [7:0] run, input t_rgba colour,
                                      input logic status);
        t_stim_row row;
        row.kind         = ROW_BYTE;
        row.reg_index    = CFG_RLE_MODE;
        row.value        = 16'(value);
        row.check        = GIVEN_PIXEL;
        row.given        = '0;
        row.given.index  = index;
        row.given.run    = run;
        row.given.colour = colour;
        row.given.status = status;
        stim_rows        = {stim_rows, row};
    endfunction

    // Offers one byte, waits for its transaction and books the expected result.
    // A gap of zero keeps valid high straight from the previous transaction.
    task automatic send_byte(input logic [7:0] value, input t_pixel_check check,
                             input t_pixel_result given);
        int            gap;
        bit            has;
        t_pixel_result res;
        gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap != 0) begin
            @(negedge i_clk);
            byte_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= value;
        do @(posedge i_clk); while (byte_ch.ready !== 1'b1);
        bytes_sent++;
        has = decode_byte(value, res);
        if (check == GIVEN_PIXEL) expected_pixels = {expected_pixels, given};
        else if (check == FROM_DECODER && has) expected_pixels = {expected_pixels, res};
    endtask

    // Brings the core to rest: no byte offered, every result collected, and
    // enough cycles for a byte that completes no pixel to leave the pipeline.
    task automatic settle_block();
        @(negedge i_clk);
        byte_ch.valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_index idx, input logic [15:0] value);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_RLE_MODE:     cfg_rle    = value[0];
            CFG_PIXEL_BITS:   cfg_bits   = value[DEPTH_W-1:0];
            CFG_IMAGE_WIDTH:  cfg_width  = value;
            CFG_IMAGE_HEIGHT: cfg_height = value;
            default: ;
        endcase
    endtask

    function automatic logic [15:0] supported_bits();
        case ($urandom_range(0, 2))
            0:       return 16'(PIXEL_BITS_16);
            1:       return 16'(PIXEL_BITS_24);
            default: return 16'(PIXEL_BITS_32);
        endcase
    endfunction

    // At a packet header, favor the boundary counts and short packets so that
    // many headers and both packet kinds turn up; elsewhere any byte will do.
    function automatic logic [7:0] next_stream_byte();
        if (cfg_rle && packet_left == 0) begin
            case ($urandom_range(0, 6))
                0: return 8'h00;
                1: return 8'h7F;
                2: return 8'h80;
                3: return 8'hFF;
                4: return 8'($urandom_range(0, 7));
                5: return 8'($urandom_range(128, 135));
                default: return 8'($urandom_range(0, 255));
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
        end
    endtask

    // Result side: stalls ready at random, then checks each transaction against
    // the oldest expected result.
    initial begin : result_sink
        int            stall;
        t_pixel_result want;
        @(posedge i_rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall != 0) begin
                @(negedge i_clk);
                pix_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            pix_ch.ready <= 1'b1;
            do @(posedge i_clk); while (pix_ch.valid !== 1'b1);
            results_seen++;
            if (expected_pixels.size() == 0) begin
                $error("result at pixel_index %0d with nothing expected", pix_ch.pixel_index);
                failures++;
            end else begin
                want = expected_pixels.pop_front();
                compare_field("pixel_index", want.index, pix_ch.pixel_index);
                compare_field("run_count", 32'(want.run), 32'(pix_ch.run_count));
                compare_field("red", 32'(want.colour.red), 32'(pix_ch.red));
                compare_field("green", 32'(want.colour.green), 32'(pix_ch.green));
                compare_field("blue", 32'(want.colour.blue), 32'(pix_ch.blue));
                compare_field("alpha", 32'(want.colour.alpha), 32'(pix_ch.alpha));
                compare_field("image_done", 32'(want.done), 32'(pix_ch.image_done));
                compare_field("status", 32'(want.status), 32'(pix_ch.status));
            end
        end
    end

    // Stimulus: directed rows, random settings and streams, then the image is
    // brought to its end so that completion and the dropping of bytes are seen.
    initial begin : stimulus
        int             phase_len;
        logic [31:0]    rows;
        logic [31:0]    cols;
        t_pixel_result  none;
        none = '0;
        @(posedge i_rst_n);

        // After reset the image is empty, so bytes vanish. Then the image is made
        // as large as the registers allow and each depth is tried: byte reorder for
        // 24 and 32 bits, 16 bits with the top bit set, an unsupported depth, and in
        // run-length mode a one-pixel repeat, a 128-pixel repeat and a raw packet.
        add_reg(CFG_IMAGE_WIDTH, 16'd0);
        add_reg(CFG_IMAGE_HEIGHT, 16'd0);
        add_byte(8'hFF, NO_PIXEL);
        add_byte(8'h00, NO_PIXEL);
        add_reg(CFG_IMAGE_WIDTH, 16'hFFFF);
        add_reg(CFG_IMAGE_HEIGHT, 16'hFFFF);
        add_byte(8'h00, NO_PIXEL);
        add_byte(8'h80, NO_PIXEL);
        add_given(8'hFF, 32'd0, 8'd1, '{red: 8'hFF, green: 8'h80, blue: 8'h00, alpha: 8'h00},
                  1'b0);
        add_reg(CFG_PIXEL_BITS, 16'(PIXEL_BITS_32));
        add_byte(8'h11, NO_PIXEL);
        add_byte(8'h22, NO_PIXEL);
        add_byte(8'h33, NO_PIXEL);
        add_given(8'h44, 32'd1, 8'd1, '{red: 8'h33, green: 8'h22, blue: 8'h11, alpha: 8'h44},
                  1'b0);
        add_reg(CFG_PIXEL_BITS, 16'(PIXEL_BITS_16));
        add_byte(8'hFF, NO_PIXEL);
        add_given(8'hFF, 32'd2, 8'd1, '{red: 8'hF8, green: 8'hF8, blue: 8'hF8, alpha: 8'h00},
                  1'b0);
        add_reg(CFG_PIXEL_BITS, 16'd0);
        add_given(8'hA5, 32'd0, 8'd0, '0, 1'b1);
        add_reg(CFG_RLE_MODE, 16'd1);
        add_reg(CFG_PIXEL_BITS, 16'(PIXEL_BITS_24));
        add_byte(8'h80, NO_PIXEL);
        add_byte(8'h01, FROM_DECODER);
        add_byte(8'h02, FROM_DECODER);
        add_byte(8'h03, FROM_DECODER);
        add_byte(8'hFF, NO_PIXEL);
        add_byte(8'h04, FROM_DECODER);
        add_byte(8'h05, FROM_DECODER);
        add_byte(8'h06, FROM_DECODER);
        add_reg(CFG_PIXEL_BITS, 16'(PIXEL_BITS_16));
        add_byte(8'h01, NO_PIXEL);
        add_byte(8'h00, FROM_DECODER);
        add_byte(8'h00, FROM_DECODER);
        add_byte(8'hE0, FROM_DECODER);
        add_byte(8'h03, FROM_DECODER);

        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_REG) begin
                settle_block();
                write_register(stim_rows[i].reg_index, stim_rows[i].value);
            end else begin
                send_byte(stim_rows[i].value[7:0], stim_rows[i].check, stim_rows[i].given);
            end
        end
        settings_used++;

        // Random part. The image stays far larger than anything the stream can
        // fill, so that completion, which only reset clears, waits for the end.
        // Settings change between phases while a pixel or packet may be half done.
        while (bytes_sent < RANDOM_BYTES) begin
            settle_block();
            no_idle = ($urandom_range(0, 3) == 0);
            write_register(CFG_RLE_MODE, 16'($urandom_range(0, 1)));
            write_register(CFG_PIXEL_BITS, ($urandom_range(0, 9) == 0) ?
                           16'($urandom_range(0, 32)) : supported_bits());
            if ($urandom_range(0, 2) == 0) begin
                write_register(CFG_IMAGE_WIDTH, 16'($urandom_range(2048, 65535)));
                write_register(CFG_IMAGE_HEIGHT, ($urandom_range(0, 3) == 0) ?
                               16'hFFFF : 16'($urandom_range(2048, 65535)));
            end
            settings_used++;
            phase_len = $urandom_range(10, 80);
            repeat (phase_len) send_byte(next_stream_byte(), FROM_DECODER, none);
        end

        // Finish the image: close the open packet, then shrink the image to just
        // past the pixels produced so far. A full repeat packet is then clamped to
        // what remains, or a full raw packet runs past the end; either way the
        // bytes after the last pixel must give nothing.
        settle_block();
        no_idle = 1'b0;
        write_register(CFG_RLE_MODE, 16'd1);
        write_register(CFG_PIXEL_BITS, supported_bits());
        while (packet_left != 0) send_byte(8'($urandom_range(0, 255)), FROM_DECODER, none);
        settle_block();
        rows = (pixels_out >> 15) + 32'd1;
        cols = (pixels_out + rows) / rows;
        write_register(CFG_IMAGE_HEIGHT, rows[15:0]);
        write_register(CFG_IMAGE_WIDTH, cols[15:0]);
        settings_used++;
        send_byte(($urandom_range(0, 1) == 0) ? 8'hFF : 8'h7F, FROM_DECODER, none);
        repeat (24) send_byte(8'($urandom_range(0, 255)), FROM_DECODER, none);

        settle_block();
        $display("Sent %0d bytes over %0d register settings; %0d results checked.",
                 bytes_sent, settings_used, results_seen);
        $display("Image completed at %0d pixels, finished flag %0b.", pixels_out,
                 image_finished);
        if (failures == 0 && expected_pixels.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin : watchdog
        #5_000_000;
        $display("Timed out with %0d results still expected.", expected_pixels.size());
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
